// ===== sv/byte_deque_remove_all_assert.svh =====
// Assertion macros for the byte deque block.
`ifndef BYTE_DEQUE_REMOVE_ALL_ASSERT_SVH
`define BYTE_DEQUE_REMOVE_ALL_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while in reset.
`define BDRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bdra assertion failed");
// Condition that must never hold.
`define BDRA_NEVER(lbl, cond) `BDRA_ASSERT(lbl, !(cond))
`else
`define BDRA_ASSERT(lbl, prop)
`define BDRA_NEVER(lbl, cond)
`endif
`endif

// ===== sv/bdra_pkg.sv =====
// Types and constants for the byte deque block.
package bdra_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned ValueW = 8;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REMOVE     = 3'd4
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

// ===== sv/byte_deque_remove_all.sv =====
// Byte deque with push/pop at both ends and remove-all-matches, over a ring store.
//
// Holds up to DEPTH bytes in a ring memory addressed by a front pointer and a
// count. Pushes, pops and unknown kinds load their result into the output
// register on the edge that accepts them. Remove-all compacts the store in place
// by streaming every held byte through the memory's single read port, one entry
// per cycle, writing kept bytes back behind the read offset. One word is worked
// on at a time; a new word is taken while the previous result waits, as long
// as it is being taken in the same cycle or the output register is empty.
`include "byte_deque_remove_all_assert.svh"

module byte_deque_remove_all #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bdra_pkg::KindW-1:0]            kind_i,
  input  logic [bdra_pkg::ValueW-1:0]           value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  status_o,
  output logic [$clog2(DEPTH+1)-1:0]            count_o
);
  import bdra_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW:0]   DepthS  = (IdxW+1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  function automatic logic [IdxW-1:0] ring_add(input logic [IdxW-1:0] base,
                                               input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[IdxW-1:0];
  endfunction

  state_e            st_q, st_d;
  logic [IdxW-1:0]   first_q, first_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   rd_off_q, rd_off_d;
  logic [CntW-1:0]   wr_off_q, wr_off_d;
  logic              pend_q, pend_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              out_valid_q, out_valid_d;
  logic              status_q, status_d;
  logic [CntW-1:0]   count_q, count_d;

  logic              in_acc;
  logic              scan_issue, scan_done;
  logic              res_load;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [ValueW-1:0] mem_wdata, mem_rdata;
  logic [IdxW-1:0]   first_dec;

  assign in_ready_o = (st_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign scan_issue = (rd_off_q < cnt_q);
  assign scan_done  = !scan_issue && !pend_q;
  assign first_dec  = (first_q == '0) ? LastIdx : first_q - IdxW'(1);

  bdra_mem #(
    .DEPTH (DEPTH),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc && (kind_e'(kind_i) == KIND_REMOVE)) begin
          st_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    first_d   = first_q;
    cnt_d     = cnt_q;
    rd_off_d  = rd_off_q;
    wr_off_d  = wr_off_q;
    pend_d    = pend_q;
    val_d     = val_q;
    mem_we    = 1'b0;
    mem_waddr = first_q;
    mem_wdata = value_i;
    mem_re    = 1'b0;
    mem_raddr = ring_add(first_q, rd_off_q[IdxW-1:0]);
    res_load  = 1'b0;
    status_d  = STATUS_FAIL;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_load = (kind_e'(kind_i) != KIND_REMOVE);
          case (kind_e'(kind_i))
            KIND_PUSH_FRONT: begin
              if (cnt_q < DepthC) begin
                first_d   = first_dec;
                mem_we    = 1'b1;
                mem_waddr = first_dec;
                cnt_d     = cnt_q + CntW'(1);
                status_d  = STATUS_OK;
              end
            end
            KIND_PUSH_BACK: begin
              if (cnt_q < DepthC) begin
                mem_we    = 1'b1;
                mem_waddr = ring_add(first_q, cnt_q[IdxW-1:0]);
                cnt_d     = cnt_q + CntW'(1);
                status_d  = STATUS_OK;
              end
            end
            KIND_POP_FRONT: begin
              if (cnt_q != '0) begin
                first_d  = ring_add(first_q, IdxW'(1));
                cnt_d    = cnt_q - CntW'(1);
                status_d = STATUS_OK;
              end
            end
            KIND_POP_BACK: begin
              if (cnt_q != '0) begin
                cnt_d    = cnt_q - CntW'(1);
                status_d = STATUS_OK;
              end
            end
            KIND_REMOVE: begin
              rd_off_d = '0;
              wr_off_d = '0;
              pend_d   = 1'b0;
              val_d    = value_i;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        mem_re   = scan_issue;
        rd_off_d = scan_issue ? rd_off_q + CntW'(1) : rd_off_q;
        pend_d   = scan_issue;
        // write offset trails read offset, so a write never hits an unread entry
        if (pend_q && (mem_rdata != val_q)) begin
          mem_we    = 1'b1;
          mem_waddr = ring_add(first_q, wr_off_q[IdxW-1:0]);
          mem_wdata = mem_rdata;
          wr_off_d  = wr_off_q + CntW'(1);
        end
        if (scan_done) begin
          res_load = 1'b1;
          cnt_d    = wr_off_q;
          status_d = (wr_off_q == cnt_q) ? STATUS_FAIL : STATUS_OK;
        end
      end
      default: ;
    endcase
    count_d = cnt_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      first_q     <= '0;
      cnt_q       <= '0;
      rd_off_q    <= '0;
      wr_off_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      rd_off_q    <= rd_off_d;
      wr_off_q    <= wr_off_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (res_load) begin
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

  `BDRA_NEVER(a_cnt_range, cnt_q > DepthC)
  `BDRA_NEVER(a_wr_behind_rd, (st_q == ST_SCAN) && (wr_off_q > rd_off_q))
  `BDRA_ASSERT(a_fast_result, in_acc && (kind_e'(kind_i) != KIND_REMOVE) |=> out_valid_o)

endmodule

// ===== sv/bdra_mem.sv =====
// Byte ring store: one write port, one read port with registered read data.
module bdra_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IdxW  = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [IdxW-1:0]               waddr_i,
  input  logic [bdra_pkg::ValueW-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [IdxW-1:0]               raddr_i,
  output logic [bdra_pkg::ValueW-1:0]   rdata_o
);
  import bdra_pkg::*;

  logic [ValueW-1:0] mem_q [DEPTH];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/byte_deque_remove_all_test.sv =====
// Self-checking testbench for the byte deque with push, pop and remove-all.
`timescale 1ns / 1ps

module byte_deque_remove_all_test;
  import bdra_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned CountW      = $clog2(DEPTH + 1);
  localparam int          STALL_LIMIT = 3000;
  localparam int          TAIL_WORDS  = 120;
  localparam int          HOLD_CYCLES = 300;

  typedef struct {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
    bit                drain;
  } word_t;

  typedef struct packed {
    logic              status;
    logic [CountW-1:0] count;
  } outcome_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [KindW-1:0]  kind_i      = KIND_PUSH_FRONT;
  logic [ValueW-1:0] value_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              status_o;
  logic [CountW-1:0] count_o;

  byte_deque_remove_all #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  // shadow deque
  logic [ValueW-1:0] shadow_bytes [DEPTH];
  logic [3:0]        shadow_front = '0;
  logic [CountW-1:0] shadow_count = '0;

  word_t    word_q[$];
  outcome_t outcome_q[$];

  int words_total  = 0;
  int words_taken  = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int send_gap     = 0;
  int ready_gap    = 0;
  int stuck_cycles = 0;
  bit hold_done    = 1'b0;
  bit tail_phase   = 1'b0;

  logic [ValueW-1:0] hot_bytes [4] = '{8'h00, 8'hFF, 8'h3C, 8'hA5};

  function automatic outcome_t deque_apply(logic [KindW-1:0] kind, logic [ValueW-1:0] value);
    outcome_t          res;
    logic              ok;
    logic [ValueW-1:0] kept [DEPTH];
    logic [3:0]        idx;
    int                n;
    ok = 1'b0;
    n  = 0;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (shadow_count < DEPTH) begin
          shadow_front = shadow_front - 4'd1;
          shadow_bytes[shadow_front] = value;
          shadow_count++;
          ok = 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (shadow_count < DEPTH) begin
          idx = shadow_front + shadow_count[3:0];
          shadow_bytes[idx] = value;
          shadow_count++;
          ok = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_count != 0) begin
          shadow_front = shadow_front + 4'd1;
          shadow_count--;
          ok = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (shadow_count != 0) begin
          shadow_count--;
          ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        for (int i = 0; i < shadow_count; i++) begin
          idx = shadow_front + 4'(i);
          if (shadow_bytes[idx] != value) begin
            kept[n] = shadow_bytes[idx];
            n++;
          end
        end
        // compacted bytes stay anchored at the front position
        if (n != shadow_count) begin
          for (int i = 0; i < n; i++) begin
            idx = shadow_front + 4'(i);
            shadow_bytes[idx] = kept[i];
          end
          shadow_count = CountW'(n);
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.status = ok ? STATUS_OK : STATUS_FAIL;
    res.count  = shadow_count;
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_word(input logic [KindW-1:0] kind, input logic [ValueW-1:0] value,
                          input bit drain);
    word_t w;
    w.kind  = kind;
    w.value = value;
    w.drain = drain;
    word_q.push_back(w);
    words_total++;
  endtask

  function automatic logic [ValueW-1:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return ValueW'($urandom_range(0, 255));
    return hot_bytes[$urandom_range(0, 3)];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    word_t w;
    bit    may_idle;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i     <= KIND_PUSH_FRONT;
      value_i    <= '0;
      send_gap    = 0;
    end else begin
      tail_phase = (word_q.size() < TAIL_WORDS);
      may_idle   = !tail_phase && ((words_taken % 200) >= 60);
      if (in_valid_i && in_ready_o) begin
        outcome_q.push_back(deque_apply(kind_i, value_i));
        words_taken++;
        if (may_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 17);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the offered word
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (word_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (word_q[0].drain && outcome_q.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        w = word_q.pop_front();
        kind_i     <= w.kind;
        value_i    <= w.value;
        in_valid_i <= 1'b1;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin : drive_ready
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_gap    = 0;
    end else begin
      // one long stall so the block backs up into its input
      if (!hold_done && results_seen >= 250) begin
        hold_done = 1'b1;
        ready_gap = HOLD_CYCLES;
      end
      if (ready_gap > 0) begin
        ready_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!tail_phase && ((results_seen % 200) < 140) && $urandom_range(0, 7) == 0)
          ready_gap = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word status=%0b count=%0d", status_o, count_o));
      end else begin
        want = outcome_q.pop_front();
        if (status_o !== want.status)
          note_mismatch($sformatf("status %0b, expected %0b", status_o, want.status));
        if (count_o !== want.count)
          note_mismatch($sformatf("count %0d, expected %0d", count_o, want.count));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int pp;
    int po;
    int r;
    int phase;
    // empty store: pops and remove fail, unknown kinds leave it alone
    add_word(KIND_POP_FRONT, 8'h00, 1'b0);
    add_word(KIND_POP_BACK, 8'hFF, 1'b0);
    add_word(KIND_REMOVE, 8'h00, 1'b0);
    for (int k = 1; k <= 3; k++) add_word(KIND_REMOVE + 3'(k), 8'hC3, 1'b0);
    // fill from both ends so the ring wraps
    for (int i = 0; i < DEPTH; i++)
      add_word(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
               (i % 3 == 0) ? 8'h5A : (i == 1) ? 8'hFF : (i == 2) ? 8'h00 : 8'(i * 17),
               1'b0);
    add_word(KIND_PUSH_FRONT, 8'h11, 1'b0);
    add_word(KIND_PUSH_BACK, 8'h22, 1'b0);
    add_word(KIND_REMOVE, 8'h77, 1'b0);
    add_word(KIND_REMOVE, 8'h5A, 1'b0);
    add_word(KIND_POP_FRONT, 8'h00, 1'b0);
    add_word(KIND_POP_BACK, 8'h00, 1'b0);

    // random part: phases lean toward filling, draining, or neither
    for (int n = 0; n < 822; n++) begin
      phase = (n / 70) % 3;
      pp = (phase == 0) ? 60 : (phase == 1) ? 20 : 40;
      po = (phase == 0) ? 15 : (phase == 1) ? 55 : 35;
      r  = $urandom_range(0, 99);
      if (r < pp)
        add_word($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_byte(),
                 n == 100 || n == 500);
      else if (r < pp + po)
        add_word($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT, pick_byte(),
                 n == 100 || n == 500);
      else if (r < 97)
        add_word(KIND_REMOVE, pick_byte(), n == 100 || n == 500);
      else
        add_word(KIND_REMOVE + 3'($urandom_range(1, 3)), pick_byte(), n == 100 || n == 500);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < words_total) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
